### hw/rtl/chacha_pkg.sv
// chacha_pkg: shared types, constants and helper functions for the chacha20 keystream xor block
// used by chacha_ctrl, chacha_dp and chacha20_keystream_xor; depends on nothing else

package chacha_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned Words     = 16;
  localparam int unsigned CfgW      = 64;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned PosW      = 7;
  localparam int unsigned RoundCntW = 7;

  // 10 double rounds, 2 half rounds each, 4 add/xor/rotate steps each
  localparam logic [RoundCntW-1:0] LastRoundStep = RoundCntW'(10 * 2 * 4 - 1);

  localparam logic [CfgIdxW-1:0] REG_KEY0      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NONCE_LO  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_NONCE_HI  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_START_CNT = 3'd6;

  localparam logic [1:0] ROLE_A = 2'd0;
  localparam logic [1:0] ROLE_B = 2'd1;
  localparam logic [1:0] ROLE_C = 2'd2;
  localparam logic [1:0] ROLE_D = 2'd3;

  localparam logic [WordW-1:0] SIGMA0 = 32'h6170_7865;
  localparam logic [WordW-1:0] SIGMA1 = 32'h3320_646e;
  localparam logic [WordW-1:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [WordW-1:0] SIGMA3 = 32'h6b20_6574;

  typedef logic [Words-1:0][WordW-1:0] block_t;

  typedef struct packed {
    logic       restart_load;
    logic       latch_data;
    logic       load_x;
    logic       round;
    logic [1:0] step;
    logic       diag;
    logic       finish;
    logic       emit;
    logic       emit_direct;
  } dp_cmd_t;

  // word index of one quarter-round operand; diagonal rounds shift rows b, c, d
  function automatic logic [3:0] qr_word(input logic diag, input logic [1:0] lane,
                                         input logic [1:0] role);
    logic [1:0] col;
    col = diag ? 2'(lane + role) : lane;
    return {role, col};
  endfunction

  function automatic logic [WordW-1:0] rol_step(input logic [WordW-1:0] v,
                                                input logic [1:0] step);
    logic [WordW-1:0] r;
    case (step)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/chacha20_keystream_xor.sv
// chacha20_keystream_xor: top level, byte stream xor with the chacha20 keystream
// depends on chacha_pkg, chacha_ctrl and chacha_dp
//
// usage:
//   s_axis carries one message byte per transfer in tdata, with the restart flag in
//   tuser; m_axis returns that byte xor-ed with the next keystream byte in tdata.
//   the cfg port writes key, nonce and start counter; write only while idle.
//   a restart reloads the block counter from start_counter and the counter/nonce
//   word from nonce word 0 plus the upper counter half, and drops the rest of the
//   current keystream block.
// throughput and sequencing:
//   a byte served from the current keystream block reaches the output register
//   in the cycle after its transfer; while m_axis_tready is high, a new byte is
//   taken every cycle. a byte needing a new block (first byte, every 64th byte,
//   or restart) goes through the load, 80 round steps of the shared quarter-round
//   datapath (four lanes, one add/xor/rotate each per cycle), the final add and emit.
// reset: counters and config cleared, keystream empty, no output valid; round state not reset.
// stall: the output register holds its byte while m_axis_tready is low and no
//   new byte is taken until it leaves.

module chacha20_keystream_xor import chacha_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // [7:0] data_byte
  input  logic               s_axis_tuser,  // [0] restart
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [7:0] out_byte
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  dp_cmd_t cmd;
  logic    need_block;

  chacha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_restart (s_axis_tuser),
    .in_ready   (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .need_block (need_block),
    .cmd        (cmd)
  );

  chacha_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_byte    (s_axis_tdata),
    .cmd        (cmd),
    .need_block (need_block),
    .out_byte   (m_axis_tdata)
  );

endmodule

### hw/rtl/chacha_dp.sv
// chacha_dp: config registers, counter words, round state, keystream block and output byte
// depends on chacha_pkg; driven by commands from chacha_ctrl

module chacha_dp import chacha_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic [7:0]         in_byte,
  input  dp_cmd_t            cmd,
  output logic               need_block,
  output logic [7:0]         out_byte
);

  logic [CfgW-1:0]  key0, key1, key2, key3, nonce_lo, start_cnt;
  logic [WordW-1:0] nonce_hi;
  logic [WordW-1:0] ctr_word, ctr_nonce_word;
  logic [PosW-1:0]  pos;
  logic [7:0]       data_hold;
  block_t           x, x_round, init_words, ks;
  logic [Words*WordW-1:0] ks_flat;
  logic [7:0]       ks_byte;

  always_comb begin
    init_words[0]  = SIGMA0;
    init_words[1]  = SIGMA1;
    init_words[2]  = SIGMA2;
    init_words[3]  = SIGMA3;
    init_words[4]  = key0[31:0];
    init_words[5]  = key0[63:32];
    init_words[6]  = key1[31:0];
    init_words[7]  = key1[63:32];
    init_words[8]  = key2[31:0];
    init_words[9]  = key2[63:32];
    init_words[10] = key3[31:0];
    init_words[11] = key3[63:32];
    init_words[12] = ctr_word;
    init_words[13] = ctr_nonce_word;
    init_words[14] = nonce_lo[63:32];
    init_words[15] = nonce_hi;
  end

  // one add/xor/rotate step on all four quarter rounds at once
  always_comb begin
    logic [3:0]       p, q, r;
    logic [WordW-1:0] sum;
    x_round = x;
    for (int lane = 0; lane < 4; lane++) begin
      if (!cmd.step[0]) begin
        p = qr_word(cmd.diag, 2'(lane), ROLE_A);
        q = qr_word(cmd.diag, 2'(lane), ROLE_B);
        r = qr_word(cmd.diag, 2'(lane), ROLE_D);
      end else begin
        p = qr_word(cmd.diag, 2'(lane), ROLE_C);
        q = qr_word(cmd.diag, 2'(lane), ROLE_D);
        r = qr_word(cmd.diag, 2'(lane), ROLE_B);
      end
      sum = x[p] + x[q];
      x_round[p] = sum;
      x_round[r] = rol_step(x[r] ^ sum, cmd.step);
    end
  end

  assign ks_flat    = ks;
  assign ks_byte    = ks_flat[pos[5:0]*8 +: 8];
  assign need_block = pos[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      key0           <= '0;
      key1           <= '0;
      key2           <= '0;
      key3           <= '0;
      nonce_lo       <= '0;
      nonce_hi       <= '0;
      start_cnt      <= '0;
      ctr_word       <= '0;
      ctr_nonce_word <= '0;
      pos            <= PosW'(64);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY0:      key0      <= cfg_data;
          REG_KEY1:      key1      <= cfg_data;
          REG_KEY2:      key2      <= cfg_data;
          REG_KEY3:      key3      <= cfg_data;
          REG_NONCE_LO:  nonce_lo  <= cfg_data;
          REG_NONCE_HI:  nonce_hi  <= cfg_data[31:0];
          REG_START_CNT: start_cnt <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.restart_load) begin
        ctr_word       <= start_cnt[31:0];
        ctr_nonce_word <= nonce_lo[31:0] + start_cnt[63:32];
        pos            <= PosW'(64);
      end
      if (cmd.finish) begin
        ctr_word <= ctr_word + 32'd1;
        if (&ctr_word) begin
          ctr_nonce_word <= ctr_nonce_word + 32'd1;
        end
        pos <= '0;
      end
      if (cmd.emit || cmd.emit_direct) begin
        pos <= pos + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_data) begin
      data_hold <= in_byte;
    end
    if (cmd.load_x) begin
      x <= init_words;
    end else if (cmd.round) begin
      x <= x_round;
    end
    if (cmd.finish) begin
      for (int i = 0; i < Words; i++) begin
        ks[i] <= x[i] + init_words[i];
      end
    end
    if (cmd.emit) begin
      out_byte <= data_hold ^ ks_byte;
    end else if (cmd.emit_direct) begin
      out_byte <= in_byte ^ ks_byte;
    end
  end

endmodule

### hw/rtl/chacha_ctrl.sv
// chacha_ctrl: handshake and sequencing state machine for the chacha20 keystream xor block
// depends on chacha_pkg; commands chacha_dp

module chacha_ctrl import chacha_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_restart,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  logic    need_block,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]           state, state_next;
  logic [RoundCntW-1:0] rcnt;
  logic                 accept, gen;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign gen      = in_restart || need_block;

  always_comb begin
    cmd          = '0;
    cmd.step     = rcnt[1:0];
    cmd.diag     = rcnt[2];
    state_next   = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (gen) begin
            cmd.restart_load = in_restart;
            cmd.latch_data   = 1'b1;
            state_next       = S_LOAD;
          end else begin
            cmd.emit_direct = 1'b1;
          end
        end
      end
      S_LOAD: begin
        cmd.load_x = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (rcnt == LastRoundStep) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ROUND) begin
        rcnt <= rcnt + RoundCntW'(1);
      end else begin
        rcnt <= '0;
      end
      if (cmd.emit || cmd.emit_direct) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
